>>> rtl/lph_pkg.sv
// Shared types, constants and helper functions of the linear-probing hash table.
// Used by lph_hash, lph_ctrl and linear_probe_hash_table; depends on nothing.
package lph_pkg;

  localparam int INDEX_BITS     = 10;
  localparam int SCORES_PER_KEY = 3;
  localparam int TAB_SIZE       = 1 << INDEX_BITS;
  localparam int IN_WORDS       = 3;
  localparam int CNT_W          = INDEX_BITS + 1;
  localparam int KEY_W          = 64;
  localparam int WORD_W         = 32;
  localparam int SLOT_W         = 10;
  localparam int COUNT_W        = 11;
  localparam int STATUS_W       = 3;

  localparam logic [KEY_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

  typedef logic [INDEX_BITS-1:0] slot_t;
  typedef logic [SCORES_PER_KEY-1:0][WORD_W-1:0] score_vec_t;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  search_key;
    logic [WORD_W-1:0] val_0;
    logic [WORD_W-1:0] val_1;
    logic [WORD_W-1:0] val_2;
    logic [WORD_W-1:0] test_0;
    logic [WORD_W-1:0] test_1;
    logic [WORD_W-1:0] test_2;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [WORD_W-1:0]   out_val_0;
    logic [WORD_W-1:0]   out_val_1;
    logic [WORD_W-1:0]   out_val_2;
    logic [WORD_W-1:0]   out_test_0;
    logic [WORD_W-1:0]   out_test_1;
    logic [WORD_W-1:0]   out_test_2;
    logic [COUNT_W-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    score_vec_t       vals;
    score_vec_t       tests;
  } entry_t;

  // Score word idx of an input word; words past the input fields are zero.
  function automatic logic [WORD_W-1:0] in_score(in_word_t w, int unsigned idx,
                                                 logic is_test);
    logic [WORD_W-1:0] r;
    r = '0;
    case (idx)
      0: r = is_test ? w.test_0 : w.val_0;
      1: r = is_test ? w.test_1 : w.val_1;
      2: r = is_test ? w.test_2 : w.val_2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Stored score word idx; zero where the entry holds fewer words.
  function automatic logic [WORD_W-1:0] pick_score(score_vec_t s, int unsigned idx);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int unsigned k = 0; k < SCORES_PER_KEY; k++) begin
      if (k == idx) begin
        r = s[k];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/lph_hash.sv
// Fibonacci home-slot unit: key times the golden-ratio constant, top bits kept.
// Uses one shared 32x32 multiplier, stepped through the states H_M0 to H_M3. Depends on lph_pkg.
module lph_hash (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [lph_pkg::KEY_W-1:0] key,
  output logic                 done,
  output lph_pkg::slot_t       slot
);
  import lph_pkg::*;

  typedef enum logic [2:0] {
    H_IDLE, H_M0, H_M1, H_M2, H_M3, H_DONE
  } hstate_t;

  hstate_t             state;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    acc;
  logic [KEY_W-1:0]    prod;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;

  // Only the low 64 bits of the product matter, so the high-by-high
  // partial product is never formed.
  always_comb begin
    mul_a = key_q[WORD_W-1:0];
    mul_b = FIB_MULT[WORD_W-1:0];
    case (state)
      H_M1:    mul_b = FIB_MULT[KEY_W-1:WORD_W];
      H_M2:    mul_a = key_q[KEY_W-1:WORD_W];
      default: mul_a = key_q[WORD_W-1:0];
    endcase
  end

  assign done = (state == H_DONE);
  assign slot = acc[KEY_W-1 -: INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else if (start) begin
      state <= H_M0;
      key_q <= key;
    end else begin
      prod <= KEY_W'(mul_a) * KEY_W'(mul_b);
      case (state)
        H_M0: begin
          state <= H_M1;
        end
        H_M1: begin
          acc   <= prod;
          state <= H_M2;
        end
        H_M2: begin
          acc[KEY_W-1:WORD_W] <= acc[KEY_W-1:WORD_W] + prod[WORD_W-1:0];
          state <= H_M3;
        end
        H_M3: begin
          acc[KEY_W-1:WORD_W] <= acc[KEY_W-1:WORD_W] + prod[WORD_W-1:0];
          state <= H_DONE;
        end
        H_DONE: begin
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lph_ctrl.sv
// Slot memory and probe sequencer: clears the table after reset, walks slots
// one per cycle and writes new records. Depends on lph_pkg.
module lph_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lph_pkg::in_word_t   item,
  output logic                idle,
  input  logic                hash_done,
  input  lph_pkg::slot_t      hash_slot,
  output logic                res_valid,
  output lph_pkg::out_word_t  res,
  input  logic                res_take
);
  import lph_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_DONE
  } state_t;

  state_t             state;
  in_word_t           item_q;
  slot_t              clr_cnt;
  slot_t              slot;
  slot_t              probe_cnt;
  logic [CNT_W-1:0]   occupancy;
  logic [CNT_W-1:0]   occ_inc;
  out_word_t          res_init;

  entry_t             mem [TAB_SIZE];
  entry_t             rd_q;
  entry_t             new_entry;
  logic               mem_we;
  logic               mem_re;
  slot_t              mem_waddr;
  slot_t              mem_raddr;
  entry_t             mem_wdata;

  logic               empty;
  logic               hit;
  logic               last;
  logic               is_insert;

  // A slot is written only when an operation ends, and the next read comes
  // after the hash of the following word, so reads and writes never overlap.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    new_entry.key = item_q.search_key;
    for (int k = 0; k < SCORES_PER_KEY; k++) begin
      new_entry.vals[k]  = in_score(item_q, k, 1'b0);
      new_entry.tests[k] = in_score(item_q, k, 1'b1);
    end
  end

  always_comb begin
    res_init             = '0;
    res_init.entry_count = COUNT_W'(occupancy);
    if (item.search_key == '0) begin
      res_init.status = ST_ZERO;
    end
  end

  assign empty     = (rd_q.key == '0);
  assign hit       = (rd_q.key == item_q.search_key);
  assign last      = (probe_cnt == '1);
  assign is_insert = (item_q.opcode == OP_INSERT);
  assign occ_inc   = occupancy + CNT_W'(1);

  assign mem_re    = (state == S_HASH && hash_done) ||
                     (state == S_PROBE && !empty && !hit && !last);
  assign mem_raddr = (state == S_HASH) ? hash_slot : slot_t'(slot + slot_t'(1));
  assign mem_we    = (state == S_CLEAR) || (state == S_PROBE && empty && is_insert);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : slot;
  assign mem_wdata = (state == S_CLEAR) ? entry_t'('0) : new_entry;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      occupancy <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + slot_t'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            res    <= res_init;
            if (item.search_key == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot      <= hash_slot;
            probe_cnt <= '0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (empty) begin
            state <= S_DONE;
            if (is_insert) begin
              occupancy       <= occ_inc;
              res.entry_count <= COUNT_W'(occ_inc);
              res.status      <= ST_OK;
              res.slot_index  <= SLOT_W'(slot);
            end else begin
              res.status <= ST_MISS;
            end
          end else if (hit) begin
            state          <= S_DONE;
            res.slot_index <= SLOT_W'(slot);
            if (is_insert) begin
              res.status <= ST_DUP;
            end else begin
              res.status     <= ST_OK;
              res.out_val_0  <= pick_score(rd_q.vals, 0);
              res.out_val_1  <= pick_score(rd_q.vals, 1);
              res.out_val_2  <= pick_score(rd_q.vals, 2);
              res.out_test_0 <= pick_score(rd_q.tests, 0);
              res.out_test_1 <= pick_score(rd_q.tests, 1);
              res.out_test_2 <= pick_score(rd_q.tests, 2);
            end
          end else if (last) begin
            state      <= S_DONE;
            res.status <= is_insert ? ST_FULL : ST_MISS;
          end else begin
            slot      <= slot + slot_t'(1);
            probe_cnt <= probe_cnt + slot_t'(1);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/linear_probe_hash_table.sv
// Top level of the linear-probing hash table with its output register.
// Instantiates lph_hash and lph_ctrl; depends on lph_pkg.
//
// Usage: the request channel (req_valid, req_stall, req) carries one word per
// operation: insert a nonzero 64-bit key with its score words, or look a key
// up. The response channel (rsp_valid, rsp_stall, rsp) returns exactly one
// word per request, in order, with status, slot, stored words and the count
// of occupied slots.
// After reset the block clears all 1024 slots, one per cycle, and holds
// req_stall high until the clear is done. Operations then run one at a time:
// the multiply steps and the settle step for the home slot, then one slot
// probed per cycle (from 1 to 1024 slots), then the result is handed over.
// The next request is taken only after the result has moved to the output
// register; the slot memory's single read port sets the one-slot-per-cycle
// probe rate. A zero key does not wait for the hash and skips the probe:
// its result goes straight to hand-over. A held response (rsp_stall high)
// does not block the next request; that request's result waits until the
// output register is free.
module linear_probe_hash_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lph_pkg::in_word_t   req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lph_pkg::out_word_t  rsp
);
  import lph_pkg::*;

  logic       accept;
  logic       ctrl_idle;
  logic       hash_done;
  slot_t      hash_slot;
  logic       res_valid;
  out_word_t  res;
  logic       res_take;

  assign req_stall = !ctrl_idle;
  assign accept    = req_valid && ctrl_idle;
  assign res_take  = !rsp_valid || !rsp_stall;

  lph_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (req.search_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .item      (req),
    .idle      (ctrl_idle),
    .hash_done (hash_done),
    .hash_slot (hash_slot),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
      if (res_valid) begin
        rsp <= res;
      end
    end
  end

endmodule
